[src/wast_pkg.sv]
// Weekly alarm schedule table: shared types, field widths, command codes, time key.
// No dependencies; every other file in src but wast_ram imports it.
package wast_pkg;

   localparam int CMD_W  = 2;
   localparam int DAY_W  = 3;
   localparam int HOUR_W = 5;
   localparam int MIN_W  = 6;
   localparam int THR_W  = 8;
   localparam int KEY_W  = 12;
   localparam int DIFF_W = KEY_W + 1;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [KEY_W-1:0] NO_NEXT_LIMIT   = 12'd2359;
   localparam logic [KEY_W-1:0] HOUR_SCALE      = 12'd100;
   localparam logic [THR_W-1:0] RESET_THRESHOLD = 8'd25;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DAY_W-1:0]  day_of_week;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [THR_W-1:0]  threshold;
      logic              enable;
      logic              repeat_flag;
      logic              relay_flag;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [THR_W-1:0]  threshold;
      logic              active;
      logic              repeat_flag;
      logic              relay_flag;
   } entry_type;

   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [THR_W-1:0]  threshold;
      logic              repeat_flag;
      logic              relay_flag;
   } sched_type;

   typedef struct packed {
      logic              fired;
      sched_type         cur;
      logic              next_found;
      logic [HOUR_W-1:0] next_hour;
      logic [MIN_W-1:0]  next_minute;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic rd_en;
      logic eval_en;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } stat_type;

   function automatic logic [KEY_W-1:0] time_key(input logic [HOUR_W-1:0] h,
                                                 input logic [MIN_W-1:0] m);
      return KEY_W'(h) * HOUR_SCALE + KEY_W'(m);
   endfunction

endpackage

[src/wast_ifs.sv]
// Weekly alarm schedule table: request and response channel interfaces.
// Depends on wast_pkg for field widths.
interface wast_req_if import wast_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DAY_W-1:0]  day_of_week;
   logic [HOUR_W-1:0] hour;
   logic [MIN_W-1:0]  minute;
   logic [THR_W-1:0]  threshold;
   logic              enable;
   logic              repeat_flag;
   logic              relay_flag;

   modport source (output valid, command, day_of_week, hour, minute, threshold, enable,
                   repeat_flag, relay_flag, input ready);
   modport sink (input valid, command, day_of_week, hour, minute, threshold, enable,
                 repeat_flag, relay_flag, output ready);
endinterface

interface wast_rsp_if import wast_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              fired;
   logic [DAY_W-1:0]  cur_day;
   logic [HOUR_W-1:0] cur_hour;
   logic [MIN_W-1:0]  cur_minute;
   logic [THR_W-1:0]  cur_threshold;
   logic              cur_repeat;
   logic              cur_relay;
   logic              next_found;
   logic [HOUR_W-1:0] next_hour;
   logic [MIN_W-1:0]  next_minute;
   logic              status;

   modport source (output valid, fired, cur_day, cur_hour, cur_minute, cur_threshold,
                   cur_repeat, cur_relay, next_found, next_hour, next_minute, status,
                   input ready);
   modport sink (input valid, fired, cur_day, cur_hour, cur_minute, cur_threshold,
                 cur_repeat, cur_relay, next_found, next_hour, next_minute, status,
                 output ready);
endinterface

[src/wast_ram.sv]
// Weekly alarm schedule table: generic single-write, single-read RAM, registered read.
// No dependencies.
module wast_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/wast_ctrl.sv]
// Weekly alarm schedule table: controller, one table entry read per scan cycle.
// Depends on wast_pkg; drives the datapath through cmd_type.
module wast_ctrl import wast_pkg::*; #(
   parameter int ENTRY_COUNT = 8,
   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stat_type         stat,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] eval_idx
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_LAST   = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             eval_en_ff, eval_en_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      cmd         = '0;
      req_ready   = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               addr_in   = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.eval_en = eval_en_ff;
      eval_en_in  = cmd.rd_en;
      eval_idx_in = addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         addr_ff     <= '0;
         eval_en_ff  <= 1'b0;
         eval_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         eval_en_ff  <= eval_en_in;
         eval_idx_ff <= eval_idx_in;
      end
   end

   assign rd_addr  = addr_ff;
   assign eval_idx = eval_idx_ff;

   a_start_to_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_SCAN) && (addr_ff == '0))
      else $error("scan did not start at entry zero");

   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE) && !eval_en_ff)
      else $error("commit left scan activity behind");

   a_eval_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> eval_en_ff && (eval_idx_ff == $past(addr_ff)))
      else $error("evaluation index does not follow read address");

endmodule

[src/wast_dp.sv]
// Weekly alarm schedule table: datapath with entry RAM, valid bits, scan trackers,
// current schedule and response register. Depends on wast_pkg and wast_ram.
module wast_dp import wast_pkg::*; #(
   parameter int ENTRY_COUNT = 8,
   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] rd_addr,
   input  logic [IDX_W-1:0] eval_idx,
   input  req_type          req_in,
   output stat_type         stat,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_out
);

   localparam int ENTRY_W = $bits(entry_type);

   req_type          req_ff;
   logic [ENTRY_COUNT-1:0] valid_ff, valid_in;
   logic             best_found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [KEY_W-1:0] best_diff_ff;
   entry_type        best_ff;
   logic             match_found_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   sched_type        cur_ff, cur_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   entry_type        rd_data;
   logic [ENTRY_W-1:0] rd_word;

   logic [KEY_W-1:0]  now_key, ent_key;
   logic [DIFF_W-1:0] diff;
   logic              ent_valid, day_hit, tick_hit, time_hit, fire;

   wast_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRY_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_data = rd_word;

   // per-entry evaluation
   always_comb begin
      now_key   = time_key(req_ff.hour, req_ff.minute);
      ent_key   = time_key(rd_data.hour, rd_data.minute);
      diff      = {1'b0, ent_key} - {1'b0, now_key};
      ent_valid = valid_ff[eval_idx];
      day_hit   = (rd_data.day == req_ff.day_of_week);
      tick_hit  = ent_valid && rd_data.active && day_hit && !diff[DIFF_W-1]
                  && (diff[KEY_W-1:0] < best_diff_ff);
      time_hit  = ent_valid && day_hit && (rd_data.hour == req_ff.hour)
                  && (rd_data.minute == req_ff.minute);
   end

   // commit of one word
   always_comb begin
      fire     = best_found_ff && (best_diff_ff == '0);
      cur_in   = cur_ff;
      valid_in = valid_ff;
      wr_en    = 1'b0;
      wr_addr  = best_idx_ff;
      wr_data  = best_ff;
      wr_data.active = 1'b0;
      rsp_in   = '0;
      if (cmd.commit) begin
         case (req_ff.command)
            CMD_TICK: begin
               rsp_in.next_found = best_found_ff;
               if (best_found_ff) begin
                  rsp_in.next_hour   = best_ff.hour;
                  rsp_in.next_minute = best_ff.minute;
               end
               if (fire) begin
                  rsp_in.fired       = 1'b1;
                  cur_in.day         = best_ff.day;
                  cur_in.hour        = best_ff.hour;
                  cur_in.minute      = best_ff.minute;
                  cur_in.threshold   = best_ff.threshold;
                  cur_in.repeat_flag = best_ff.repeat_flag;
                  cur_in.relay_flag  = best_ff.relay_flag;
                  wr_en              = !best_ff.repeat_flag;
               end
            end
            CMD_CREATE: begin
               if (match_found_ff || free_found_ff) begin
                  wr_en               = 1'b1;
                  wr_addr             = match_found_ff ? match_idx_ff : free_idx_ff;
                  wr_data.day         = req_ff.day_of_week;
                  wr_data.hour        = req_ff.hour;
                  wr_data.minute      = req_ff.minute;
                  wr_data.threshold   = req_ff.threshold;
                  wr_data.active      = req_ff.enable;
                  wr_data.repeat_flag = req_ff.repeat_flag;
                  wr_data.relay_flag  = req_ff.relay_flag;
                  valid_in[wr_addr]   = 1'b1;
               end else begin
                  rsp_in.status = 1'b1;
               end
            end
            CMD_DELETE: begin
               if (match_found_ff) begin
                  valid_in[match_idx_ff] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      rsp_in.cur   = cur_in;
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '{day: '0, hour: '0, minute: '0, threshold: RESET_THRESHOLD,
                           repeat_flag: 1'b1, relay_flag: 1'b0};
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff         <= req_in;
         best_found_ff  <= 1'b0;
         best_diff_ff   <= NO_NEXT_LIMIT;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.eval_en) begin
         if (tick_hit) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= eval_idx;
            best_diff_ff  <= diff[KEY_W-1:0];
            best_ff       <= rd_data;
         end
         if (time_hit && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= eval_idx;
         end
         if (!ent_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= eval_idx;
         end
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out       = rsp_ff;

   a_full_means_all_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.command == CMD_CREATE) && !match_found_ff && !free_found_ff)
      |-> (&valid_ff))
      else $error("create dropped while a slot was free");

   a_fired_matches_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fired) |-> (rsp_ff.next_found
         && (rsp_ff.next_hour == rsp_ff.cur.hour) && (rsp_ff.next_minute == rsp_ff.cur.minute)))
      else $error("fired word disagrees with next entry");

   a_status_excludes_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> (!rsp_ff.fired && !rsp_ff.next_found))
      else $error("full status on a tick word");

endmodule

[src/weekly_alarm_schedule_table_top.sv]
// Weekly alarm schedule table: top level joining controller and datapath.
// Depends on wast_pkg, wast_ifs, wast_ctrl, wast_dp (and wast_ram below it).
//
//   channel   dir  handshake     word
//   req_chan  in   valid/ready   command, day/time, threshold, enable, repeat, relay
//   rsp_chan  out  valid/ready   fired, current schedule, next entry, status
//
// Each word scans the whole table, one entry RAM read per cycle, then passes an
// evaluate step for the last entry and a commit step that waits for a free response.
// Reset clears all valid bits and loads the default current schedule at once.
// A finished word waits in the response register; the next request is taken
// meanwhile and only its commit stalls until the response is taken.
module weekly_alarm_schedule_table_top import wast_pkg::*; #(
   parameter int ENTRY_COUNT = 8
) (
   input logic            clock,
   input logic            reset,
   wast_req_if.sink       req_chan,
   wast_rsp_if.source     rsp_chan
);

   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

   cmd_type          cmd;
   stat_type         stat;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] eval_idx;
   req_type          req_word;
   rsp_type          rsp_word;

   assign req_word = '{command: req_chan.command, day_of_week: req_chan.day_of_week,
                       hour: req_chan.hour, minute: req_chan.minute,
                       threshold: req_chan.threshold, enable: req_chan.enable,
                       repeat_flag: req_chan.repeat_flag, relay_flag: req_chan.relay_flag};

   wast_ctrl #(.ENTRY_COUNT(ENTRY_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .eval_idx  (eval_idx)
   );

   wast_dp #(.ENTRY_COUNT(ENTRY_COUNT)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .eval_idx  (eval_idx),
      .req_in    (req_word),
      .stat      (stat),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_out   (rsp_word)
   );

   assign rsp_chan.fired         = rsp_word.fired;
   assign rsp_chan.cur_day       = rsp_word.cur.day;
   assign rsp_chan.cur_hour      = rsp_word.cur.hour;
   assign rsp_chan.cur_minute    = rsp_word.cur.minute;
   assign rsp_chan.cur_threshold = rsp_word.cur.threshold;
   assign rsp_chan.cur_repeat    = rsp_word.cur.repeat_flag;
   assign rsp_chan.cur_relay     = rsp_word.cur.relay_flag;
   assign rsp_chan.next_found    = rsp_word.next_found;
   assign rsp_chan.next_hour     = rsp_word.next_hour;
   assign rsp_chan.next_minute   = rsp_word.next_minute;
   assign rsp_chan.status        = rsp_word.status;

endmodule
